### hw/rtl/spline_tangent_tcb_macros.svh
// Assertion macros used by the checker of the tangent block.
`ifndef SPLINE_TANGENT_TCB_MACROS_SVH
`define SPLINE_TANGENT_TCB_MACROS_SVH

// Overlapping implication, sampled on the rising clock edge, off during reset.
`define STCB_ASSERT_IMP(name, clk_i, rstn_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// Implication onto the following cycle.
`define STCB_ASSERT_NXT(name, clk_i, rstn_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/stcb_pkg.sv
// Package of the tangent block: widths, register indexes, types and the Q12 helper.
package stcb_pkg;

	localparam int VAL_W      = 32;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int TCB_W      = 14;
	localparam int TIME_W     = 16;
	localparam int FRAC_BITS  = 12;
	localparam int RATIO_SHIFT = 13;
	localparam int HALF_SHIFT = 11;

	// Divider: the dividend magnitude is a 16-bit time difference shifted by FRAC_BITS.
	localparam int DEN_W      = TIME_W + 1;
	localparam int DIV_W      = TIME_W + FRAC_BITS;
	localparam int DIV_CNT_W  = $clog2(DIV_W);

	localparam logic signed [VAL_W-1:0] ONE_Q12  = VAL_W'(1 << FRAC_BITS);
	localparam logic signed [VAL_W-1:0] Q12_BIAS = VAL_W'((1 << FRAC_BITS) - 1);

	localparam logic [CFG_IDX_W-1:0] REG_TENSION    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONTINUITY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_T_END      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_T_START    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_T_REF      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd6;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_LOAD,
		CS_DIV,
		CS_MUL,
		CS_ACC
	} coef_state_t;

	// Steps of the shared coefficient multiplier.
	typedef enum logic [2:0] {
		STEP_WA_LO,
		STEP_WA_HI,
		STEP_WB_LO,
		STEP_WB_HI,
		STEP_SCALE
	} coef_step_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] s;
		logic signed [VAL_W-1:0] wa;
		logic signed [VAL_W-1:0] wb;
		logic signed [VAL_W-1:0] wab;
		logic                    incoming_only;
	} coef_t;

	// Signed divide by 4096, truncating toward zero.
	function automatic logic signed [VAL_W-1:0] q12(input logic signed [VAL_W-1:0] v);
		logic signed [VAL_W-1:0] adj;
		adj = v + (v[VAL_W-1] ? Q12_BIAS : '0);
		return adj >>> FRAC_BITS;
	endfunction

endpackage

### hw/rtl/stcb_coef.sv
// Configuration registers and the sequencer that derives the scale and weights.
module stcb_coef (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [stcb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [stcb_pkg::CFG_W-1:0]     cfg_data,
	output stcb_pkg::coef_t                coef,
	output logic                           busy
);
	import stcb_pkg::*;

	logic [TCB_W-1:0]  tension_q, bias_q, cont_q;
	logic [TIME_W-1:0] t_end_q, t_start_q, t_ref_q;
	logic              mode_q;

	coef_state_t state_q, state_d;
	coef_step_t  step_q;

	logic [DEN_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic signed [VAL_W-1:0] p_q, x_q, s_q, wa_q, wb_q, wab_q;

	logic                    cfg_hit;
	logic signed [VAL_W-1:0] t_ext, b_ext, c_ext, one_t, ac;
	logic signed [DEN_W-1:0] num_diff, den_diff;
	logic [TIME_W-1:0]       num_mag, den_mag;
	logic                    degenerate, neg;
	logic [DEN_W-1:0]        trial;
	logic                    qbit;
	logic signed [VAL_W-1:0] ratio, ratio_shl, s0;
	logic signed [VAL_W-1:0] mul_a, mul_b, prod;
	logic signed [VAL_W-1:0] pq, half_shl, w_next;
	logic                    last_div, last_step;

	assign cfg_hit = cfg_we && (cfg_index <= REG_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tension_q <= '0;
			bias_q    <= '0;
			cont_q    <= '0;
			t_end_q   <= '0;
			t_start_q <= '0;
			t_ref_q   <= '0;
			mode_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TENSION:    tension_q <= cfg_data[TCB_W-1:0];
				REG_BIAS:       bias_q    <= cfg_data[TCB_W-1:0];
				REG_CONTINUITY: cont_q    <= cfg_data[TCB_W-1:0];
				REG_T_END:      t_end_q   <= cfg_data[TIME_W-1:0];
				REG_T_START:    t_start_q <= cfg_data[TIME_W-1:0];
				REG_T_REF:      t_ref_q   <= cfg_data[TIME_W-1:0];
				REG_MODE:       mode_q    <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	assign t_ext = {{(VAL_W-TCB_W){tension_q[TCB_W-1]}}, tension_q};
	assign b_ext = {{(VAL_W-TCB_W){bias_q[TCB_W-1]}}, bias_q};
	assign c_ext = {{(VAL_W-TCB_W){cont_q[TCB_W-1]}}, cont_q};
	assign one_t = ONE_Q12 - t_ext;
	assign ac    = (c_ext > 0) ? c_ext : -c_ext;

	// Time ratio divider works on magnitudes; the sign is put back afterwards.
	assign num_diff   = {t_end_q[TIME_W-1], t_end_q} - {t_start_q[TIME_W-1], t_start_q};
	assign den_diff   = {t_ref_q[TIME_W-1], t_ref_q} - {t_start_q[TIME_W-1], t_start_q};
	assign num_mag    = TIME_W'(num_diff[DEN_W-1] ? -num_diff : num_diff);
	assign den_mag    = TIME_W'(den_diff[DEN_W-1] ? -den_diff : den_diff);
	assign neg        = num_diff[DEN_W-1] ^ den_diff[DEN_W-1];
	assign degenerate = (t_ref_q == t_end_q) || (t_ref_q == t_start_q);

	assign trial    = {rem_q[DEN_W-2:0], quo_q[DIV_W-1]};
	assign qbit     = trial >= {1'b0, den_mag};
	assign last_div = cnt_q == DIV_CNT_W'(DIV_W - 1);

	assign ratio     = neg ? -VAL_W'(quo_q) : VAL_W'(quo_q);
	assign ratio_shl = {ratio[VAL_W-1-RATIO_SHIFT:0], {RATIO_SHIFT{1'b0}}};
	assign s0        = degenerate ? '0 : q12(ratio_shl);

	always_comb begin
		unique case (step_q)
			STEP_WA_LO: begin
				mul_a = one_t;
				mul_b = ONE_Q12 - c_ext;
			end
			STEP_WA_HI: begin
				mul_a = x_q;
				mul_b = b_ext + ONE_Q12;
			end
			STEP_WB_LO: begin
				mul_a = one_t;
				mul_b = ONE_Q12 + c_ext;
			end
			STEP_WB_HI: begin
				mul_a = x_q;
				mul_b = ONE_Q12 - b_ext;
			end
			STEP_SCALE: begin
				mul_a = ac;
				mul_b = s_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = mul_a * mul_b;
	assign pq       = q12(p_q);
	assign half_shl = {pq[VAL_W-1-HALF_SHIFT:0], {HALF_SHIFT{1'b0}}};
	assign w_next   = q12(half_shl);
	assign last_step = step_q == STEP_SCALE;

	always_comb begin
		state_d = state_q;
		if (cfg_hit) begin
			state_d = CS_LOAD;
		end else begin
			unique case (state_q)
				CS_IDLE: state_d = CS_IDLE;
				CS_LOAD: state_d = CS_DIV;
				CS_DIV:  state_d = last_div ? CS_MUL : CS_DIV;
				CS_MUL:  state_d = CS_ACC;
				CS_ACC:  state_d = last_step ? CS_IDLE : CS_MUL;
				default: state_d = CS_IDLE;
			endcase
		end
	end

	always_comb begin
		busy = state_q != CS_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WA_LO;
			cnt_q  <= '0;
		end else if (state_q == CS_LOAD) begin
			step_q <= STEP_WA_LO;
			cnt_q  <= '0;
		end else if (state_q == CS_DIV) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (state_q == CS_ACC && !last_step) begin
			step_q <= coef_step_t'(step_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			CS_LOAD: begin
				quo_q <= {num_mag, {FRAC_BITS{1'b0}}};
				rem_q <= '0;
			end
			CS_DIV: begin
				quo_q <= {quo_q[DIV_W-2:0], qbit};
				rem_q <= qbit ? (trial - {1'b0, den_mag}) : trial;
			end
			CS_MUL: begin
				p_q <= prod;
			end
			CS_ACC: begin
				unique case (step_q)
					STEP_WA_LO: begin
						x_q <= pq;
						s_q <= s0;
					end
					STEP_WA_HI: wa_q <= w_next;
					STEP_WB_LO: x_q  <= pq;
					STEP_WB_HI: wb_q <= w_next;
					STEP_SCALE: begin
						s_q   <= s_q + ac - pq;
						wab_q <= wa_q + wb_q;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign coef.s             = s_q;
	assign coef.wa            = wa_q;
	assign coef.wb            = wb_q;
	assign coef.wab           = wab_q;
	assign coef.incoming_only = mode_q;

endmodule

### hw/rtl/stcb_pipe.sv
// Per-point datapath: differences, weighting, scaling and the result register.
module stcb_pipe (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [stcb_pkg::VAL_W-1:0] prev_value,
	input  logic signed [stcb_pkg::VAL_W-1:0] cur_value,
	input  logic signed [stcb_pkg::VAL_W-1:0] next_value,
	input  logic                              last_point,
	input  stcb_pkg::coef_t                   coef,
	output logic                              done,
	output logic signed [stcb_pkg::VAL_W-1:0] tangent,
	output logic                              last_out
);
	import stcb_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, done_q;
	logic last_s1, last_s2, last_s3, last_s4, last_q;
	logic signed [VAL_W-1:0] da_s1, db_s1;
	logic signed [VAL_W-1:0] pa_s2, pb_s2;
	logic signed [VAL_W-1:0] sum_s3;
	logic signed [VAL_W-1:0] sum_s4, prod_s4;
	logic signed [VAL_W-1:0] tangent_q;
	logic signed [VAL_W-1:0] wsel;

	// In incoming-only mode the summed weight goes onto the incoming difference.
	assign wsel = coef.incoming_only ? coef.wab : coef.wa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= in_valid;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		da_s1   <= cur_value - prev_value;
		db_s1   <= next_value - cur_value;
		last_s1 <= last_point;

		pa_s2   <= wsel * da_s1;
		pb_s2   <= coef.wb * db_s1;
		last_s2 <= last_s1;

		sum_s3  <= coef.incoming_only ? q12(pa_s2) : (q12(pa_s2) + q12(pb_s2));
		last_s3 <= last_s2;

		sum_s4  <= sum_s3;
		prod_s4 <= coef.s * sum_s3;
		last_s4 <= last_s3;

		tangent_q <= coef.incoming_only ? sum_s4 : q12(prod_s4);
		last_q    <= last_s4;
	end

	assign done     = done_q;
	assign tangent  = tangent_q;
	assign last_out = last_q;

endmodule

### hw/rtl/spline_tangent_tcb.sv
// Top level of the Kochanek-Bartels outgoing tangent block.
//
//  channel   | signals                                        | handshake
//  ----------+------------------------------------------------+--------------------------
//  point in  | prev_value, cur_value, next_value, last_point  | start, taken when !busy
//  result    | tangent, last_out                              | done, one cycle, no stall
//  config    | cfg_index, cfg_data                            | cfg_we, taken at once
//
// One point word is taken per cycle while busy is low; its result comes out with done.
// After reset and after every register write the scale and weights are recomputed:
// a restoring divider for the time ratio, then five steps of a shared multiplier,
// each a multiply state and an accumulate state, with busy high throughout.
// The result side cannot stall, so the pipeline never holds a word back.
module spline_tangent_tcb (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [stcb_pkg::VAL_W-1:0] prev_value,
	input  logic signed [stcb_pkg::VAL_W-1:0] cur_value,
	input  logic signed [stcb_pkg::VAL_W-1:0] next_value,
	input  logic                              last_point,
	output logic                              done,
	output logic signed [stcb_pkg::VAL_W-1:0] tangent,
	output logic                              last_out,
	input  logic                              cfg_we,
	input  logic [stcb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [stcb_pkg::CFG_W-1:0]        cfg_data
);
	import stcb_pkg::*;

	coef_t coef;
	logic  coef_busy;
	logic  accept;

	assign accept = start && !coef_busy;
	assign busy   = coef_busy;

	stcb_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef),
		.busy      (coef_busy)
	);

	stcb_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.prev_value (prev_value),
		.cur_value  (cur_value),
		.next_value (next_value),
		.last_point (last_point),
		.coef       (coef),
		.done       (done),
		.tangent    (tangent),
		.last_out   (last_out)
	);

endmodule

### hw/rtl/stcb_chk.sv
// Port-level checker of the tangent block and its bind to the top level.
`include "spline_tangent_tcb_macros.svh"

module stcb_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           last_point,
	input logic                           done,
	input logic                           last_out,
	input logic                           cfg_we,
	input logic [stcb_pkg::CFG_IDX_W-1:0] cfg_index
);
	import stcb_pkg::*;

	// Every accepted word comes out with done, and done rises for nothing else.
	`STCB_ASSERT_IMP(a_result_follows, clk, arst_n, start && !busy, ##5 done, "accepted word gave no result")
	`STCB_ASSERT_IMP(a_no_spurious, clk, arst_n, done, $past(start && !busy, 5), "result without a word")
	`STCB_ASSERT_IMP(a_last_kept, clk, arst_n, done, last_out == $past(last_point, 5), "last flag lost")
	// A register write must hold off new words while the weights are rebuilt.
	`STCB_ASSERT_NXT(a_busy_after_cfg, clk, arst_n, cfg_we && (cfg_index <= REG_MODE), busy, "no recompute after write")

endmodule

bind spline_tangent_tcb stcb_chk u_stcb_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.last_point (last_point),
	.done       (done),
	.last_out   (last_out),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index)
);

### test/tb_spline_tangent_tcb.sv
// Self-checking testbench for the Kochanek-Bartels outgoing tangent block.
module tb_spline_tangent_tcb;
	import stcb_pkg::*;

	localparam int UNIT = 4096;

	typedef struct {
		logic signed [VAL_W-1:0] prev;
		logic signed [VAL_W-1:0] cur;
		logic signed [VAL_W-1:0] nxt;
		logic                    last;
	} key_point_t;

	typedef struct {
		logic signed [VAL_W-1:0] tangent;
		logic                    last;
	} tangent_word_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic signed [VAL_W-1:0] prev_value = '0;
	logic signed [VAL_W-1:0] cur_value = '0;
	logic signed [VAL_W-1:0] next_value = '0;
	logic                    last_point = 1'b0;
	logic                    done;
	logic signed [VAL_W-1:0] tangent;
	logic                    last_out;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_TENSION;
	logic [CFG_W-1:0]        cfg_data = '0;

	key_point_t    point_queue[$];
	tangent_word_t expected_tangents[$];
	logic [CFG_W-1:0] kb_regs [0:6] = '{default: '0};
	logic          word_taken = 1'b0;
	int            idle_pct = 0;
	int            fail_count = 0;

	spline_tangent_tcb dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.prev_value (prev_value),
		.cur_value  (cur_value),
		.next_value (next_value),
		.last_point (last_point),
		.done       (done),
		.tangent    (tangent),
		.last_out   (last_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	// Expected tangent for one point under the current register contents.
	function automatic int predict_tangent(input int prev, input int cur, input int nxt);
		int t, b, c, te, ts, tr, one_t, ratio, s, ac, wa, wb, da, db;
		t = int'($signed(kb_regs[REG_TENSION][TCB_W-1:0]));
		b = int'($signed(kb_regs[REG_BIAS][TCB_W-1:0]));
		c = int'($signed(kb_regs[REG_CONTINUITY][TCB_W-1:0]));
		te = int'($signed(kb_regs[REG_T_END][TIME_W-1:0]));
		ts = int'($signed(kb_regs[REG_T_START][TIME_W-1:0]));
		tr = int'($signed(kb_regs[REG_T_REF][TIME_W-1:0]));
		one_t = UNIT - t;
		// A reference time on either end of the interval gives a zero ratio.
		if (tr == te || tr == ts) begin
			s = 0;
		end else begin
			ratio = ((te - ts) * UNIT) / (tr - ts);
			s = (ratio << RATIO_SHIFT) / UNIT;
		end
		ac = (c > 0) ? c : -c;
		s = s + ac - (ac * s) / UNIT;
		wa = (((((one_t * (UNIT - c)) / UNIT) * (b + UNIT)) / UNIT) << HALF_SHIFT) / UNIT;
		wb = (((((one_t * (c + UNIT)) / UNIT) * (UNIT - b)) / UNIT) << HALF_SHIFT) / UNIT;
		da = cur - prev;
		db = nxt - cur;
		if (kb_regs[REG_MODE][0])
			return ((wa + wb) * da) / UNIT;
		return (s * ((wa * da) / UNIT + (wb * db) / UNIT)) / UNIT;
	endfunction

	// Driver: a word is held on the ports until the block takes it.
	always @(negedge clk) begin : drive_points
		key_point_t p;
		if (!start || word_taken) begin
			if (point_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
				p = point_queue.pop_front();
				prev_value <= p.prev;
				cur_value <= p.cur;
				next_value <= p.nxt;
				last_point <= p.last;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: predicts on acceptance, checks each result word, tracks register writes.
	always @(posedge clk) begin : watch_block
		tangent_word_t w;
		word_taken <= start && !busy;
		if (arst_n) begin
			if (start && !busy) begin
				w.tangent = predict_tangent(prev_value, cur_value, next_value);
				w.last = last_point;
				expected_tangents.push_back(w);
			end
			if (done) begin
				if (expected_tangents.size() == 0) begin
					$error("tangent word with no expectation waiting: tangent %0d", tangent);
					fail_count++;
				end else begin
					w = expected_tangents.pop_front();
					if (tangent !== w.tangent) begin
						$error("tangent: expected %0d, actual %0d", w.tangent, tangent);
						fail_count++;
					end
					if (last_out !== w.last) begin
						$error("last_out: expected %0b, actual %0b", w.last, last_out);
						fail_count++;
					end
				end
			end
			if (cfg_we && cfg_index <= REG_MODE)
				kb_regs[cfg_index] = cfg_data;
		end
	end

	task automatic wait_idle();
		while (point_queue.size() != 0 || start || expected_tangents.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
	endtask

	task automatic apply_setting(input int t, input int b, input int c, input int te,
			input int ts, input int tr, input int mode);
		wait_idle();
		write_reg(REG_TENSION, t);
		write_reg(REG_BIAS, b);
		write_reg(REG_CONTINUITY, c);
		write_reg(REG_T_END, te);
		write_reg(REG_T_START, ts);
		write_reg(REG_T_REF, tr);
		write_reg(REG_MODE, mode);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_point(input int prev, input int cur, input int nxt, input logic last);
		key_point_t p;
		p.prev = prev;
		p.cur = cur;
		p.nxt = nxt;
		p.last = last;
		point_queue.push_back(p);
	endtask

	// Wrapping differences, zero and unit steps, and a mixed-sign case.
	task automatic push_directed_points();
		push_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
		push_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b1);
		push_point(0, 0, 0, 1'b0);
		push_point(-1, 0, 1, 1'b0);
		push_point(100000, -5, 70000, 1'b1);
	endtask

	function automatic int rand_key();
		case ($urandom_range(3))
			0: return int'($urandom());
			1: return int'($urandom_range(2000)) - 1000;
			2: return int'($urandom_range(1 << 20)) - (1 << 19);
			default: begin
				case ($urandom_range(3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return -1;
					default: return 0;
				endcase
			end
		endcase
	endfunction

	function automatic int rand_coef();
		case ($urandom_range(5))
			0: return -UNIT;
			1: return UNIT;
			2: return 0;
			default: return int'($urandom_range(2 * UNIT)) - UNIT;
		endcase
	endfunction

	task automatic random_setting();
		int te, ts, tr;
		te = int'($signed(16'($urandom())));
		ts = int'($signed(16'($urandom())));
		case ($urandom_range(5))
			0: tr = te;
			1: tr = ts;
			2: tr = ts + (($urandom_range(1)) ? 1 : -1);
			default: tr = int'($signed(16'($urandom())));
		endcase
		apply_setting(rand_coef(), rand_coef(), rand_coef(), te, ts, tr,
				int'($urandom_range(1)));
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		apply_setting(0, 0, 0, 1, 0, 2, 0);
		push_directed_points();
		apply_setting(-UNIT, UNIT, -UNIT, 32767, -32768, -32767, 0);
		push_directed_points();
		apply_setting(UNIT, -UNIT, UNIT, 100, 0, 100, 0);
		push_directed_points();
		apply_setting(1234, -2000, 3000, -32768, 500, 500, 1);
		push_directed_points();
		apply_setting(-UNIT, -UNIT, UNIT, -1, 32767, -32768, 1);
		push_directed_points();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: idle_pct = 6;
				1: idle_pct = 67;
				default: idle_pct = 0;
			endcase
			for (int k = 0; k < 4; k++) begin
				random_setting();
				for (int n = 0; n < 48; n++)
					push_point(rand_key(), rand_key(), rand_key(), 1'($urandom_range(1)));
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_tangents.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
